@@ sv/hed_pkg.sv @@
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, character codes and helper functions of the hex escape
// decoder: phase encoding, result group and hex digit handling.
// ----------------------------------------------------------------------------
package hed_pkg;

	localparam int BYTE_W  = 8;
	localparam int MAX_OUT = 4;
	localparam int IDX_W   = $clog2(MAX_OUT);
	localparam int CNT_W   = $clog2(MAX_OUT + 1);

	// Character codes
	localparam logic [BYTE_W-1:0] CHAR_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CHAR_X      = 8'h78;
	localparam logic [BYTE_W-1:0] CHAR_0      = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_9      = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_UA     = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_UF     = 8'h46;
	localparam logic [BYTE_W-1:0] CHAR_LA     = 8'h61;
	localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h66;

	// Escape phase, one-hot
	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_BS   = 4'b0010,
		PH_X    = 4'b0100,
		PH_D1   = 4'b1000
	} phase_t;

	// Result bytes caused by one input beat
	typedef struct packed {
		logic [CNT_W-1:0]                cnt;
		logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
		logic                            last;
	} grp_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// Classify a byte as a hex digit and give its value
	function automatic hex_t hex_val(logic [BYTE_W-1:0] b);
		hex_t r;
		r.ok  = 1'b0;
		r.val = b[3:0];
		if (b >= CHAR_0 && b <= CHAR_9) begin
			r.ok = 1'b1;
		end else if ((b >= CHAR_UA && b <= CHAR_UF) || (b >= CHAR_LA && b <= CHAR_LF)) begin
			r.ok  = 1'b1;
			r.val = b[3:0] + 4'd9;
		end
		return r;
	endfunction

	// Rebuild the character of a held digit in its original case
	function automatic logic [BYTE_W-1:0] digit_char(logic [3:0] v, logic lower);
		logic [BYTE_W-1:0] r;
		if (v < 4'd10) begin
			r = CHAR_0 | BYTE_W'(v);
		end else begin
			r = (lower ? CHAR_LA : CHAR_UA) + BYTE_W'(v) - BYTE_W'(10);
		end
		return r;
	endfunction

	// Append one byte to a group
	function automatic grp_t grp_push(grp_t g, logic [BYTE_W-1:0] b);
		grp_t r;
		r = g;
		if (g.cnt < CNT_W'(MAX_OUT)) begin
			r.bytes[g.cnt[IDX_W-1:0]] = b;
			r.cnt = g.cnt + CNT_W'(1);
		end
		return r;
	endfunction

	// Append the bytes held by a pending escape
	function automatic grp_t grp_held(grp_t g, phase_t ph, logic [3:0] nib, logic lower);
		grp_t r;
		r = g;
		if (ph == PH_BS || ph == PH_X || ph == PH_D1) begin
			r = grp_push(r, CHAR_BSLASH);
		end
		if (ph == PH_X || ph == PH_D1) begin
			r = grp_push(r, CHAR_X);
		end
		if (ph == PH_D1) begin
			r = grp_push(r, digit_char(nib, lower));
		end
		return r;
	endfunction

endpackage

@@ sv/hed_if.sv @@
// ----------------------------------------------------------------------------
// hed_if
// Valid/ready channels of the hex escape decoder: raw byte input and
// decoded byte output.
// ----------------------------------------------------------------------------
interface hed_in_if;
	logic                       valid;
	logic                       ready;
	logic [hed_pkg::BYTE_W-1:0] data_byte;
	logic                       is_last;

	modport source (output valid, data_byte, is_last, input ready);
	modport sink   (input valid, data_byte, is_last, output ready);
endinterface

interface hed_out_if;
	logic                       valid;
	logic                       ready;
	logic [hed_pkg::BYTE_W-1:0] out_byte;
	logic                       out_last;

	modport source (output valid, out_byte, out_last, input ready);
	modport sink   (input valid, out_byte, out_last, output ready);
endinterface

@@ sv/hex_escape_decoder.sv @@
// Path: an input beat is registered in the input stage, decoded, and its results
// are registered in the result group register, from which they are offered.
// Throughput: one input beat per cycle while each beat yields at most one result
// and the output is ready; after a beat with more (up to four), beats with results
// wait while the single result group register drains one byte per output beat taken.
// Reset: arst_n clears the escape phase, the input stage and the result group.
// ----------------------------------------------------------------------------
// hex_escape_decoder
// Replaces backslash, 'x', two hex digits with the byte they encode and
// passes every other byte through; broken escapes are replayed unchanged.
// ----------------------------------------------------------------------------
module hex_escape_decoder (
	input  logic       clk,
	input  logic       arst_n,
	hed_in_if.sink     raw,
	hed_out_if.source  dec
);

	// Input stage
	logic                       valid_s1;
	logic [hed_pkg::BYTE_W-1:0] byte_s1;
	logic                       last_s1;

	// Escape state
	hed_pkg::phase_t phase_q;
	logic [3:0]      nib_q;
	logic            lower_q;

	// Result group
	logic [hed_pkg::CNT_W-1:0]                       grp_cnt_q;
	logic [hed_pkg::MAX_OUT-1:0][hed_pkg::BYTE_W-1:0] grp_bytes_q;
	logic                                            grp_last_q;

	hed_pkg::grp_t   grp;
	hed_pkg::phase_t ph_nx;
	logic [3:0]      nib_nx;
	logic            lower_nx;
	hed_pkg::hex_t   hv;
	logic            retry;
	logic            beat_out;
	logic            adv;

	assign beat_out = dec.valid && dec.ready;

	// Advance the stage when the group register is free, frees now, or is not needed
	assign adv = valid_s1 && (grp_cnt_q == '0 || (grp_cnt_q == hed_pkg::CNT_W'(1) && dec.ready)
		|| grp.cnt == '0);
	assign raw.ready = !valid_s1 || adv;

	// Decode one byte against the pending escape
	always_comb begin
		grp      = '0;
		ph_nx    = phase_q;
		nib_nx   = nib_q;
		lower_nx = lower_q;
		hv       = hed_pkg::hex_val(byte_s1);
		retry    = 1'b0;
		unique case (phase_q)
			hed_pkg::PH_IDLE: begin
				retry = 1'b1;
			end
			hed_pkg::PH_BS: begin
				if (byte_s1 == hed_pkg::CHAR_X) begin
					ph_nx = hed_pkg::PH_X;
				end else begin
					grp   = hed_pkg::grp_held(grp, phase_q, nib_q, lower_q);
					retry = 1'b1;
				end
			end
			hed_pkg::PH_X: begin
				if (hv.ok) begin
					ph_nx    = hed_pkg::PH_D1;
					nib_nx   = hv.val;
					lower_nx = byte_s1 >= hed_pkg::CHAR_LA;
				end else begin
					grp   = hed_pkg::grp_held(grp, phase_q, nib_q, lower_q);
					retry = 1'b1;
				end
			end
			hed_pkg::PH_D1: begin
				if (hv.ok) begin
					grp   = hed_pkg::grp_push(grp, {nib_q, hv.val});
					ph_nx = hed_pkg::PH_IDLE;
				end else begin
					grp   = hed_pkg::grp_held(grp, phase_q, nib_q, lower_q);
					retry = 1'b1;
				end
			end
			default: begin
				ph_nx = hed_pkg::PH_IDLE;
				retry = 1'b1;
			end
		endcase

		// Handle the byte afresh from the idle phase
		if (retry) begin
			if (byte_s1 == hed_pkg::CHAR_BSLASH) begin
				ph_nx = hed_pkg::PH_BS;
			end else begin
				ph_nx = hed_pkg::PH_IDLE;
				grp   = hed_pkg::grp_push(grp, byte_s1);
			end
		end

		// Flush held bytes at the end of the stream
		if (last_s1) begin
			grp      = hed_pkg::grp_held(grp, ph_nx, nib_nx, lower_nx);
			grp.last = 1'b1;
			ph_nx    = hed_pkg::PH_IDLE;
			nib_nx   = '0;
			lower_nx = 1'b0;
		end
	end

	// Input stage: take a beat whenever the stage is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.ready && raw.valid) begin
			byte_s1 <= raw.data_byte;
			last_s1 <= raw.is_last;
		end
	end

	// Escape state: update as the stage advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hed_pkg::PH_IDLE;
			nib_q   <= '0;
			lower_q <= 1'b0;
		end else if (adv) begin
			phase_q <= ph_nx;
			nib_q   <= nib_nx;
			lower_q <= lower_nx;
		end
	end

	// Result group: load a new group, or drop the byte just sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_cnt_q <= '0;
		end else if (adv && grp.cnt != '0) begin
			grp_cnt_q <= grp.cnt;
		end else if (beat_out) begin
			grp_cnt_q <= grp_cnt_q - hed_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && grp.cnt != '0) begin
			grp_bytes_q <= grp.bytes;
			grp_last_q  <= grp.last;
		end else if (beat_out) begin
			grp_bytes_q <= grp_bytes_q >> hed_pkg::BYTE_W;
		end
	end

	assign dec.valid    = grp_cnt_q != '0;
	assign dec.out_byte = grp_bytes_q[0];
	assign dec.out_last = grp_last_q && grp_cnt_q == hed_pkg::CNT_W'(1);

endmodule

@@ sv/hed_checker.sv @@
// ----------------------------------------------------------------------------
// hed_checker
// Port-level checks of the hex escape decoder, bound into hex_escape_decoder.
// ----------------------------------------------------------------------------
module hed_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       raw_valid,
	input logic                       raw_ready,
	input logic                       dec_valid,
	input logic                       dec_ready,
	input logic [hed_pkg::BYTE_W-1:0] dec_byte,
	input logic                       dec_last
);

	// Hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !dec_ready |=> dec_valid && $stable(dec_byte) && $stable(dec_last))
		else $error("output beat changed while stalled");

	// Stall input only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!raw_ready |-> dec_valid)
		else $error("input stalled with no result pending");

	// A fresh result must have a matching input beat, taken through the input stage
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dec_valid) |-> $past(raw_valid && raw_ready, 2))
		else $error("result appeared without a matching input beat");

	// Offer nothing while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !dec_valid)
		else $error("result offered during reset");

endmodule

bind hex_escape_decoder hed_checker u_hed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.raw_valid (raw.valid),
	.raw_ready (raw.ready),
	.dec_valid (dec.valid),
	.dec_ready (dec.ready),
	.dec_byte  (dec.out_byte),
	.dec_last  (dec.out_last)
);
